/* src/kssct_pkg.sv */
// Shared constants and codes for the keyed start/stop condition table.
package kssct_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int SOFT_LIMIT  = 48;
  localparam int KEY_WIDTH   = 32;
  localparam int COUNT_WIDTH = 16;

  // Port widths fixed by the item format
  localparam int KEY_PORT_W  = 32;
  localparam int COND_W      = 2;
  localparam int TRACK_W     = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 1;

  // Derived widths
  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int SCAN_W = $clog2(TABLE_DEPTH + 1);
  localparam int OCC_W  = $clog2(TABLE_DEPTH + 1);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Condition codes
  localparam logic [COND_W-1:0] COND_UNKNOWN = 2'd0;
  localparam logic [COND_W-1:0] COND_FALSE   = 2'd1;
  localparam logic [COND_W-1:0] COND_TRUE    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NEST_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_FALSE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICED        = 2'd2;

endpackage

/* src/keyed_start_stop_condition_table.sv */
// Keyed start/stop condition table: scanned key table with per-key start counts.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one event beat: start, stop
//   and stop-all match flags plus a key. Output channel (out_valid_o /
//   out_stall_i) returns one result beat per event: condition, changed,
//   dropped, over-soft-limit and the number of occupied entries.
//   The configuration port (cfg_we_i, cfg_idx_i, cfg_data_i) writes the
//   nesting mode (0), initial_false (1) and sliced (2); write it while idle.
// Timing:
//   An event walks the whole key table through one memory read port, one
//   entry per cycle, and an update step then writes the table and loads the
//   result. A stop-all beat skips the scan and goes straight to the update
//   step. The next event is taken the cycle after the previous result is
//   loaded.
// Reset:
//   Clears all valid bits, the occupancy count, the forced-false flag and the
//   configuration; the key and count memories are not cleared.
// Stall:
//   A result waits in the output register while the receiver stalls; the
//   next event may be scanned meanwhile, and its update holds until the
//   output register is free.
module keyed_start_stop_condition_table
  import kssct_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // event channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  start_matched_i,
  input  logic                  stop_matched_i,
  input  logic                  stop_all_matched_i,
  input  logic [KEY_PORT_W-1:0] entry_key_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COND_W-1:0]     condition_o,
  output logic                  changed_o,
  output logic                  dropped_o,
  output logic                  over_soft_limit_o,
  output logic [TRACK_W-1:0]    tracked_count_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e                  state_q;
  logic                    nesting_q, init_false_q, sliced_q, forced_q;
  logic [TABLE_DEPTH-1:0]  valid_q;
  logic [OCC_W-1:0]        occ_q;

  // captured event
  logic                    start_q, stop_q, all_q;
  logic [KEY_WIDTH-1:0]    key_q;

  // scan pipeline
  logic [SCAN_W-1:0]       scan_q;
  logic                    rd_vld_q;
  logic [IDX_W-1:0]        rd_idx_q;
  logic [KEY_WIDTH-1:0]    rd_key_q;
  logic [COUNT_WIDTH-1:0]  rd_cnt_q;

  // scan findings
  logic                    found_q, free_found_q, any_true_q;
  logic [IDX_W-1:0]        match_idx_q, free_idx_q;
  logic [COUNT_WIDTH-1:0]  match_cnt_q;

  // result register
  logic                    out_valid_q;
  logic [COND_W-1:0]       cond_q;
  logic                    chg_q, drop_q, soft_q;
  logic [OCC_W-1:0]        track_q;

  // memories
  logic [KEY_WIDTH-1:0]    key_mem [TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0]  cnt_mem [TABLE_DEPTH];

  logic                    in_acc, out_acc, scan_rd, out_free, load_res;
  logic                    rd_hit, rd_free, rd_true;

  // update decision
  logic                    dflt_false;
  logic [COND_W-1:0]       dflt_cond;
  logic                    is_start;
  logic [COUNT_WIDTH-1:0]  cnt_dec;
  logic [COUNT_WIDTH-1:0]  new_cnt;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_idx;
  logic [KEY_WIDTH-1:0]    wr_key;
  logic [COUNT_WIDTH-1:0]  wr_cnt;
  logic                    set_vld, clr_vld, clr_all, occ_inc, occ_dec;
  logic [COND_W-1:0]       res_cond;
  logic                    res_chg, res_drop, res_soft;
  logic [OCC_W-1:0]        occ_next;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign scan_rd     = (state_q == S_SCAN) && (scan_q < SCAN_W'(TABLE_DEPTH));
  assign load_res    = (state_q == S_DONE) && out_free;

  // Compare the entry read last cycle
  assign rd_hit  = rd_vld_q && valid_q[rd_idx_q] && (rd_key_q == key_q);
  assign rd_free = rd_vld_q && !valid_q[rd_idx_q];
  assign rd_true = rd_vld_q && valid_q[rd_idx_q] && (rd_cnt_q != '0);

  // Decide the result and the table update
  assign dflt_false = init_false_q || forced_q;
  assign dflt_cond  = dflt_false ? COND_FALSE : COND_UNKNOWN;
  assign is_start   = start_q && !stop_q;

  always_comb begin
    wr_en    = 1'b0;
    wr_idx   = match_idx_q;
    wr_key   = key_q;
    wr_cnt   = match_cnt_q;
    set_vld  = 1'b0;
    clr_vld  = 1'b0;
    clr_all  = 1'b0;
    occ_inc  = 1'b0;
    occ_dec  = 1'b0;
    res_cond = dflt_cond;
    res_chg  = 1'b0;
    res_drop = 1'b0;
    res_soft = 1'b0;
    cnt_dec  = nesting_q ? (match_cnt_q - COUNT_WIDTH'(1)) : '0;
    new_cnt  = match_cnt_q;

    if (all_q) begin
      clr_all  = 1'b1;
      res_cond = COND_FALSE;
      res_chg  = !(dflt_false && (occ_q == '0));
    end else if (!start_q && !stop_q) begin
      if (sliced_q) begin
        if (any_true_q) begin
          res_cond = COND_TRUE;
        end
      end else if (found_q) begin
        res_cond = (match_cnt_q != '0) ? COND_TRUE : COND_FALSE;
      end
    end else if (!found_q) begin
      res_soft = sliced_q && (32'(occ_q) >= SOFT_LIMIT);
      if (!free_found_q) begin
        res_cond = COND_UNKNOWN;
        res_drop = 1'b1;
      end else begin
        res_cond = is_start ? COND_TRUE : COND_FALSE;
        if (is_start || !dflt_false) begin
          wr_en   = 1'b1;
          wr_idx  = free_idx_q;
          wr_cnt  = is_start ? COUNT_WIDTH'(1) : '0;
          set_vld = 1'b1;
          occ_inc = 1'b1;
          res_chg = 1'b1;
        end
      end
    end else if (is_start) begin
      res_chg  = (match_cnt_q == '0);
      new_cnt  = (match_cnt_q == COUNT_MAX) ? match_cnt_q : match_cnt_q + COUNT_WIDTH'(1);
      wr_en    = 1'b1;
      wr_cnt   = new_cnt;
      res_cond = COND_TRUE;
    end else begin
      res_cond = (match_cnt_q != '0) ? COND_TRUE : COND_FALSE;
      if (match_cnt_q != '0) begin
        new_cnt = cnt_dec;
        if (cnt_dec == '0) begin
          res_cond = COND_FALSE;
          res_chg  = 1'b1;
        end
      end
      wr_en  = 1'b1;
      wr_cnt = new_cnt;
      if (dflt_false && (new_cnt == '0)) begin
        clr_vld = 1'b1;
        occ_dec = 1'b1;
      end
    end

    if (clr_all) begin
      occ_next = '0;
    end else if (occ_inc) begin
      occ_next = occ_q + OCC_W'(1);
    end else if (occ_dec) begin
      occ_next = occ_q - OCC_W'(1);
    end else begin
      occ_next = occ_q;
    end
  end

  // Key and count memories: one read port for the scan, one write port
  always_ff @(posedge clk_i) begin
    if (scan_rd) begin
      rd_key_q <= key_mem[scan_q[IDX_W-1:0]];
      rd_cnt_q <= cnt_mem[scan_q[IDX_W-1:0]];
    end
    if (load_res && wr_en) begin
      key_mem[wr_idx] <= wr_key;
      cnt_mem[wr_idx] <= wr_cnt;
    end
  end

  // Sequencer, table control and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      nesting_q    <= 1'b0;
      init_false_q <= 1'b0;
      sliced_q     <= 1'b0;
      forced_q     <= 1'b0;
      valid_q      <= '0;
      occ_q        <= '0;
      start_q      <= 1'b0;
      stop_q       <= 1'b0;
      all_q        <= 1'b0;
      key_q        <= '0;
      scan_q       <= '0;
      rd_vld_q     <= 1'b0;
      rd_idx_q     <= '0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      any_true_q   <= 1'b0;
      match_idx_q  <= '0;
      free_idx_q   <= '0;
      match_cnt_q  <= '0;
      out_valid_q  <= 1'b0;
      cond_q       <= COND_UNKNOWN;
      chg_q        <= 1'b0;
      drop_q       <= 1'b0;
      soft_q       <= 1'b0;
      track_q      <= '0;
    end else begin
      // take configuration writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_NEST_MODE:     nesting_q    <= cfg_data_i[0];
          CFG_INITIAL_FALSE: init_false_q <= cfg_data_i[0];
          CFG_SLICED:        sliced_q     <= cfg_data_i[0];
          default: ;
        endcase
      end

      // load a new result beat, or drop the one taken
      if (load_res) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end

      // advance the read pipeline
      rd_vld_q <= scan_rd;
      rd_idx_q <= scan_q[IDX_W-1:0];

      // collect scan findings
      if (rd_hit && !found_q) begin
        found_q     <= 1'b1;
        match_idx_q <= rd_idx_q;
        match_cnt_q <= rd_cnt_q;
      end
      if (rd_free && !free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= rd_idx_q;
      end
      if (rd_true) begin
        any_true_q <= 1'b1;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            start_q      <= start_matched_i;
            stop_q       <= stop_matched_i;
            all_q        <= stop_all_matched_i;
            key_q        <= sliced_q ? KEY_WIDTH'(entry_key_i) : '0;
            scan_q       <= '0;
            found_q      <= 1'b0;
            free_found_q <= 1'b0;
            any_true_q   <= 1'b0;
            state_q      <= stop_all_matched_i ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_q == SCAN_W'(TABLE_DEPTH)) begin
            state_q <= S_DONE;
          end else begin
            scan_q <= scan_q + SCAN_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            if (clr_all) begin
              valid_q  <= '0;
              forced_q <= 1'b1;
            end else if (set_vld) begin
              valid_q[wr_idx] <= 1'b1;
            end else if (clr_vld) begin
              valid_q[wr_idx] <= 1'b0;
            end
            occ_q       <= occ_next;
            cond_q      <= res_cond;
            chg_q       <= res_chg;
            drop_q      <= res_drop;
            soft_q      <= res_soft;
            track_q     <= occ_next;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign condition_o       = cond_q;
  assign changed_o         = chg_q;
  assign dropped_o         = drop_q;
  assign over_soft_limit_o = soft_q;
  assign tracked_count_o   = TRACK_W'(track_q);

  // Occupancy always matches the number of valid entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == 32'(occ_q))
    else $error("occupancy out of step with valid bits");

  // A new result beat only comes from the update step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside the update step");

  // A refused key reports an unknown condition and no change
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && drop_q) |-> (cond_q == COND_UNKNOWN && !chg_q))
    else $error("dropped beat with a known condition");

  // The scan never runs past the end of the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (scan_q <= SCAN_W'(TABLE_DEPTH)))
    else $error("scan index past table end");

endmodule

/* bench/keyed_start_stop_condition_table_tb.sv */
// Self-checking testbench for the keyed start/stop condition table.
`timescale 1ns / 1ps

module keyed_start_stop_condition_table_tb;
  import kssct_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int CHOKE_LEN      = 500;
  localparam int TAIL_CYCLES    = 80;
  localparam int KEY_POOL       = 72;
  localparam int PHASES         = 6;

  typedef struct packed {
    logic                  start;
    logic                  stop;
    logic                  halt_all;
    logic [KEY_PORT_W-1:0] key;
  } event_t;

  typedef struct packed {
    logic [COND_W-1:0]  cond;
    logic               changed;
    logic               dropped;
    logic               over_soft;
    logic [TRACK_W-1:0] tracked;
  } verdict_t;

  typedef enum logic { ROW_EVENT, ROW_WRITE } row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 reg_val;
    event_t               ev;
    logic                 typed;
    verdict_t             want;
  } step_t;

  localparam event_t   NO_EV = '0;
  localparam verdict_t NO_V  = '0;

  // Directed plan: register writes and event beats, typed results where obvious
  localparam int PLAN_LEN = 30;
  localparam step_t PLAN [PLAN_LEN] = '{
    // unsliced, default unknown, stop clears the count
    '{ROW_EVENT, CFG_NEST_MODE, 1'b0, '{1'b0, 1'b0, 1'b0, 32'h0000_0000},
      1'b1, '{COND_UNKNOWN, 1'b0, 1'b0, 1'b0, 7'd0}},
    '{ROW_EVENT, CFG_NEST_MODE, 1'b0, '{1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF},
      1'b1, '{COND_FALSE, 1'b1, 1'b0, 1'b0, 7'd1}},
    '{ROW_EVENT, CFG_NEST_MODE, 1'b0, '{1'b1, 1'b0, 1'b0, 32'h0000_0000},
      1'b1, '{COND_TRUE, 1'b1, 1'b0, 1'b0, 7'd1}},
    '{ROW_EVENT, CFG_NEST_MODE, 1'b0, '{1'b1, 1'b0, 1'b0, 32'h1234_5678}, 1'b0, NO_V},
    '{ROW_EVENT, CFG_NEST_MODE, 1'b0, '{1'b0, 1'b0, 1'b0, 32'h8765_4321}, 1'b0, NO_V},
    '{ROW_EVENT, CFG_NEST_MODE, 1'b0, '{1'b0, 1'b1, 1'b0, 32'h0000_0000},
      1'b1, '{COND_FALSE, 1'b1, 1'b0, 1'b0, 7'd1}},
    // sliced with nesting
    '{ROW_WRITE, CFG_NEST_MODE,     1'b1, NO_EV, 1'b0, NO_V},
    '{ROW_WRITE, CFG_SLICED,        1'b1, NO_EV, 1'b0, NO_V},
    '{ROW_EVENT, CFG_NEST_MODE, 1'b0, '{1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF}, 1'b0, NO_V},
    '{ROW_EVENT, CFG_NEST_MODE, 1'b0, '{1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF}, 1'b0, NO_V},
    '{ROW_EVENT, CFG_NEST_MODE, 1'b0, '{1'b0, 1'b0, 1'b0, 32'h0000_0000}, 1'b0, NO_V},
    '{ROW_EVENT, CFG_NEST_MODE, 1'b0, '{1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF}, 1'b0, NO_V},
    '{ROW_EVENT, CFG_NEST_MODE, 1'b0, '{1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF}, 1'b0, NO_V},
    '{ROW_EVENT, CFG_NEST_MODE, 1'b0, '{1'b1, 1'b1, 1'b0, 32'h0000_0001}, 1'b0, NO_V},
    '{ROW_EVENT, CFG_NEST_MODE, 1'b0, '{1'b0, 1'b0, 1'b0, 32'h0000_0001}, 1'b0, NO_V},
    // default false: zero-count entries get erased
    '{ROW_WRITE, CFG_INITIAL_FALSE, 1'b1, NO_EV, 1'b0, NO_V},
    '{ROW_EVENT, CFG_NEST_MODE, 1'b0, '{1'b0, 1'b1, 1'b0, 32'h0000_0001}, 1'b0, NO_V},
    '{ROW_EVENT, CFG_NEST_MODE, 1'b0, '{1'b1, 1'b0, 1'b0, 32'hA5A5_A5A5}, 1'b0, NO_V},
    // stop-all overrides everything, then again on an empty table
    '{ROW_EVENT, CFG_NEST_MODE, 1'b0, '{1'b1, 1'b1, 1'b1, 32'hAAAA_AAAA},
      1'b1, '{COND_FALSE, 1'b1, 1'b0, 1'b0, 7'd0}},
    '{ROW_EVENT, CFG_NEST_MODE, 1'b0, '{1'b0, 1'b0, 1'b1, 32'h5555_5555},
      1'b1, '{COND_FALSE, 1'b0, 1'b0, 1'b0, 7'd0}},
    // forced false survives clearing initial_false
    '{ROW_WRITE, CFG_INITIAL_FALSE, 1'b0, NO_EV, 1'b0, NO_V},
    '{ROW_EVENT, CFG_NEST_MODE, 1'b0, '{1'b0, 1'b1, 1'b0, 32'h5555_5555},
      1'b1, '{COND_FALSE, 1'b0, 1'b0, 1'b0, 7'd0}},
    '{ROW_EVENT, CFG_NEST_MODE, 1'b0, '{1'b1, 1'b0, 1'b0, 32'h8000_0000},
      1'b1, '{COND_TRUE, 1'b1, 1'b0, 1'b0, 7'd1}},
    '{ROW_EVENT, CFG_NEST_MODE, 1'b0, '{1'b1, 1'b0, 1'b0, 32'h8000_0000}, 1'b0, NO_V},
    '{ROW_EVENT, CFG_NEST_MODE, 1'b0, '{1'b0, 1'b1, 1'b0, 32'h8000_0000}, 1'b0, NO_V},
    '{ROW_EVENT, CFG_NEST_MODE, 1'b0, '{1'b0, 1'b1, 1'b0, 32'h8000_0000}, 1'b0, NO_V},
    // back to a single default entry
    '{ROW_WRITE, CFG_SLICED,        1'b0, NO_EV, 1'b0, NO_V},
    '{ROW_EVENT, CFG_NEST_MODE, 1'b0, '{1'b0, 1'b0, 1'b0, 32'h7FFF_FFFE}, 1'b0, NO_V},
    '{ROW_EVENT, CFG_NEST_MODE, 1'b0, '{1'b1, 1'b0, 1'b0, 32'h0F0F_0F0F}, 1'b0, NO_V},
    '{ROW_EVENT, CFG_NEST_MODE, 1'b0, '{1'b0, 1'b1, 1'b0, 32'hF0F0_F0F0}, 1'b0, NO_V}
  };

  // Random phases: {nesting, initial_false, sliced} and beat count
  localparam logic [2:0] PHASE_MODE  [PHASES] =
    '{3'b101, 3'b011, 3'b110, 3'b001, 3'b100, 3'b111};
  localparam int         PHASE_ITEMS [PHASES] = '{400, 400, 250, 400, 250, 250};

  // Clock, reset and block inputs
  logic                  clk_i           = 1'b0;
  logic                  rst_n           = 1'b0;
  logic                  cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx         = '0;
  logic [CFG_DATA_W-1:0] cfg_data        = '0;
  logic                  in_valid        = 1'b0;
  logic                  start_matched   = 1'b0;
  logic                  stop_matched    = 1'b0;
  logic                  stop_all_match  = 1'b0;
  logic [KEY_PORT_W-1:0] entry_key       = '0;
  logic                  out_stall       = 1'b0;

  // Block outputs
  logic                  in_stall;
  logic                  out_valid;
  logic [COND_W-1:0]     condition;
  logic                  changed;
  logic                  dropped;
  logic                  over_soft;
  logic [TRACK_W-1:0]    tracked;

  // Shadow of the key table and its configuration
  logic [KEY_PORT_W-1:0]  tbl_key   [TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0] tbl_count [TABLE_DEPTH];
  logic                   tbl_used  [TABLE_DEPTH];
  int                     tbl_fill      = 0;
  logic                   stopped_all   = 1'b0;
  logic                   mode_nesting  = 1'b0;
  logic                   mode_init_f   = 1'b0;
  logic                   mode_sliced   = 1'b0;

  verdict_t due_verdicts [$];
  int       mismatches    = 0;
  int       sent_count    = 0;
  int       send_idle_pct = 7;
  int       recv_idle_pct = 85;
  int       choke_left    = 0;
  int       next_choke_at = 150;
  int       quiet_cycles  = 0;
  logic [KEY_PORT_W-1:0] key_pool [KEY_POOL];

  keyed_start_stop_condition_table uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .start_matched_i    (start_matched),
    .stop_matched_i     (stop_matched),
    .stop_all_matched_i (stop_all_match),
    .entry_key_i        (entry_key),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .condition_o        (condition),
    .changed_o          (changed),
    .dropped_o          (dropped),
    .over_soft_limit_o  (over_soft),
    .tracked_count_o    (tracked)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_used[i]  = 1'b0;
      tbl_key[i]   = '0;
      tbl_count[i] = '0;
    end
  end

  // Slot holding the key, or -1
  function automatic int find_slot(logic [KEY_PORT_W-1:0] k);
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (tbl_used[i] && tbl_key[i] == k) return i;
    return -1;
  endfunction

  // Advance the shadow table by one event beat and return its result
  function automatic verdict_t apply_event(event_t ev);
    verdict_t              v;
    logic [KEY_PORT_W-1:0] k;
    logic                  dflt_false;
    logic [COND_W-1:0]     dflt;
    logic                  going_up;
    int                    hit;
    int                    free_slot;
    v          = '0;
    k          = mode_sliced ? ev.key : '0;
    dflt_false = mode_init_f | stopped_all;
    dflt       = dflt_false ? COND_FALSE : COND_UNKNOWN;
    if (ev.halt_all) begin
      // clear everything and force the default to false
      v.changed = !(dflt_false && tbl_fill == 0);
      for (int i = 0; i < TABLE_DEPTH; i++) tbl_used[i] = 1'b0;
      tbl_fill    = 0;
      stopped_all = 1'b1;
      v.cond      = COND_FALSE;
    end else if (!ev.start && !ev.stop) begin
      // query only
      v.cond = dflt;
      if (mode_sliced) begin
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (tbl_used[i] && tbl_count[i] != 0) v.cond = COND_TRUE;
      end else begin
        hit = find_slot('0);
        if (hit >= 0) v.cond = (tbl_count[hit] != 0) ? COND_TRUE : COND_FALSE;
      end
    end else begin
      going_up = ev.start && !ev.stop;
      hit      = find_slot(k);
      if (hit < 0) begin
        // unknown key: take a free slot or drop the beat
        free_slot = -1;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
          if (!tbl_used[i]) free_slot = i;
        v.over_soft = mode_sliced && tbl_fill >= SOFT_LIMIT;
        if (free_slot < 0) begin
          v.cond    = COND_UNKNOWN;
          v.dropped = 1'b1;
        end else begin
          v.cond = going_up ? COND_TRUE : COND_FALSE;
          if (going_up || !dflt_false) begin
            tbl_used[free_slot]  = 1'b1;
            tbl_key[free_slot]   = k;
            tbl_count[free_slot] = going_up ? COUNT_WIDTH'(1) : '0;
            tbl_fill++;
            v.changed = 1'b1;
          end
        end
      end else begin
        v.cond = (tbl_count[hit] != 0) ? COND_TRUE : COND_FALSE;
        if (going_up) begin
          if (tbl_count[hit] == 0) v.changed = 1'b1;
          if (tbl_count[hit] != COUNT_MAX) tbl_count[hit]++;
          v.cond = COND_TRUE;
        end else begin
          if (tbl_count[hit] != 0) begin
            tbl_count[hit] = mode_nesting ? tbl_count[hit] - 1'b1 : '0;
            if (tbl_count[hit] == 0) begin
              v.cond    = COND_FALSE;
              v.changed = 1'b1;
            end
          end
          // free idle entries when the default is false
          if (dflt_false && tbl_count[hit] == 0) begin
            tbl_used[hit] = 1'b0;
            tbl_fill--;
          end
        end
      end
    end
    v.tracked = TRACK_W'(tbl_fill);
    return v;
  endfunction

  // Offer one beat, hold it until taken, then record its expected result
  task automatic offer_event(event_t ev, logic typed, verdict_t want);
    logic     taken;
    verdict_t v;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid       <= 1'b1;
    start_matched  <= ev.start;
    stop_matched   <= ev.stop;
    stop_all_match <= ev.halt_all;
    entry_key      <= ev.key;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = in_valid && !in_stall;
    end
    v = apply_event(ev);
    due_verdicts.push_back(typed ? want : v);
    sent_count++;
  endtask

  // Drop valid and wait until every result is back
  task automatic quiesce();
    in_valid <= 1'b0;
    while (due_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_NEST_MODE:     mode_nesting = val;
      CFG_INITIAL_FALSE: mode_init_f  = val;
      CFG_SLICED:        mode_sliced  = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic note_mismatch(string what, verdict_t want);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected cond=%0d chg=%0b drop=%0b soft=%0b trk=%0d,",
               $time, what, want.cond, want.changed, want.dropped, want.over_soft,
               want.tracked,
               " got cond=%0d chg=%0b drop=%0b soft=%0b trk=%0d",
               condition, changed, dropped, over_soft, tracked);
  endtask

  // Check each result beat against the oldest expectation
  always @(posedge clk_i) begin : check_beats
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_verdicts.size() == 0) begin
        note_mismatch("unexpected result beat", NO_V);
      end else begin
        want = due_verdicts.pop_front();
        if (condition !== want.cond || changed !== want.changed ||
            dropped !== want.dropped || over_soft !== want.over_soft ||
            tracked !== want.tracked)
          note_mismatch("result mismatch", want);
      end
    end
  end

  // Receiver: random stall, with a long hold-off now and then
  always @(posedge clk_i) begin
    if (choke_left > 0) begin
      out_stall  <= 1'b1;
      choke_left <= choke_left - 1;
    end else if (sent_count >= next_choke_at) begin
      out_stall     <= 1'b1;
      choke_left    <= CHOKE_LEN;
      next_choke_at <= next_choke_at + 700;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("keyed_start_stop_condition_table_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus
  initial begin : stimulus
    event_t ev;
    int     drawn;
    int     r;
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed plan
    for (int s = 0; s < PLAN_LEN; s++) begin
      if (PLAN[s].kind == ROW_WRITE) begin
        quiesce();
        write_reg(PLAN[s].reg_idx, PLAN[s].reg_val);
      end else begin
        offer_event(PLAN[s].ev, PLAN[s].typed, PLAN[s].want);
      end
    end

    // random phases, mostly starts and stops on a reused key pool
    drawn = 0;
    for (int p = 0; p < PHASES; p++) begin
      quiesce();
      write_reg(CFG_NEST_MODE,     PHASE_MODE[p][2]);
      write_reg(CFG_INITIAL_FALSE, PHASE_MODE[p][1]);
      write_reg(CFG_SLICED,        PHASE_MODE[p][0]);
      for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
        if (drawn < 650) begin
          send_idle_pct = 7;
          recv_idle_pct = 85;
        end else if (drawn < 1300) begin
          send_idle_pct = 85;
          recv_idle_pct = 7;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        ev.key      = ($urandom_range(0, 19) == 0) ? KEY_PORT_W'($urandom)
                                                   : key_pool[$urandom_range(0, KEY_POOL - 1)];
        ev.start    = 1'($urandom_range(0, 1));
        ev.stop     = 1'($urandom_range(0, 1));
        ev.halt_all = 1'b0;
        r = $urandom_range(0, 999);
        if (r < 5) begin
          ev.halt_all = 1'b1;
        end else if (r < 70) begin
          ev.start = 1'b0;
          ev.stop  = 1'b0;
        end else if (r < 100) begin
          ev.start = 1'b1;
          ev.stop  = 1'b1;
        end else if (r < 380) begin
          ev.start = 1'b0;
          ev.stop  = 1'b1;
        end else begin
          ev.start = 1'b1;
          ev.stop  = 1'b0;
        end
        offer_event(ev, 1'b0, NO_V);
        drawn++;
      end
    end

    // drain and let the pipeline settle
    quiesce();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && due_verdicts.size() == 0)
      $display("keyed_start_stop_condition_table_tb OK");
    else
      $display("keyed_start_stop_condition_table_tb NOT OK");
    $finish;
  end

endmodule

/* sim.f */
src/kssct_pkg.sv
src/keyed_start_stop_condition_table.sv
bench/keyed_start_stop_condition_table_tb.sv
